/* rtl/core/grid_two_border_reachability_defines.svh */
// assertion macros for the grid two-border reachability block
`ifndef GRID_TWO_BORDER_REACHABILITY_DEFINES_SVH
`define GRID_TWO_BORDER_REACHABILITY_DEFINES_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define GTBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define GTBR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define GTBR_ASSERT(lbl, prop, msg)
`define GTBR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* rtl/core/gtbr_pkg.sv */
// shared types and constants for the grid two-border reachability block
package gtbr_pkg;

  localparam int CfgIdxBits  = 8;
  localparam int CfgDataBits = 8;
  localparam int SizeBits    = 6;

  localparam logic [CfgIdxBits-1:0] CFG_ROW_COUNT = 8'd0;
  localparam logic [CfgIdxBits-1:0] CFG_COL_COUNT = 8'd1;

  typedef enum logic [8:0] {
    S_LOAD   = 9'b000000001,
    S_CLR    = 9'b000000010,
    S_CAND_A = 9'b000000100,
    S_CAND_B = 9'b000001000,
    S_POP1   = 9'b000010000,
    S_POP2   = 9'b000100000,
    S_EMIT1  = 9'b001000000,
    S_EMIT2  = 9'b010000000,
    S_EMIT3  = 9'b100000000
  } state_t;

endpackage

/* rtl/core/gtbr_cand.sv */
// candidate cell generator: border seeds and the four neighbors of a cell
module gtbr_cand #(
  parameter int RB = 5,
  parameter int CB = 5,
  parameter int KW = 6
) (
  input  logic          seeding,
  input  logic          fill,
  input  logic [KW-1:0] k,
  input  logic [1:0]    nb,
  input  logic [RB-1:0] cur_r,
  input  logic [CB-1:0] cur_c,
  input  logic [RB-1:0] rows_m1,
  input  logic [CB-1:0] cols_m1,
  output logic          ok,
  output logic          last,
  output logic [RB-1:0] r,
  output logic [CB-1:0] c
);

  logic [KW:0] k_ext;
  logic [KW:0] cols_ext;
  logic [KW:0] rows_ext;
  logic [KW:0] rdiff;

  assign k_ext    = (KW+1)'(k);
  assign cols_ext = (KW+1)'(cols_m1) + (KW+1)'(1);
  assign rows_ext = (KW+1)'(rows_m1) + (KW+1)'(1);
  assign rdiff    = k_ext - cols_ext;

  // seeds walk the row border first, then the column border
  always_comb begin
    ok   = 1'b1;
    last = 1'b0;
    r    = cur_r;
    c    = cur_c;
    if (seeding) begin
      last = (k_ext == rows_ext + cols_ext - (KW+1)'(1));
      if (k_ext < cols_ext) begin
        r = fill ? rows_m1 : '0;
        c = CB'(k);
      end else begin
        r = RB'(rdiff);
        c = fill ? cols_m1 : '0;
      end
    end else begin
      last = (nb == 2'd3);
      case (nb)
        2'd0: begin
          ok = (cur_r != '0);
          r  = cur_r - RB'(1);
        end
        2'd1: begin
          ok = (cur_r != rows_m1);
          r  = cur_r + RB'(1);
        end
        2'd2: begin
          ok = (cur_c != '0);
          c  = cur_c - CB'(1);
        end
        default: begin
          ok = (cur_c != cols_m1);
          c  = cur_c + CB'(1);
        end
      endcase
    end
  end

endmodule

/* rtl/core/grid_two_border_reachability.sv */
// grid two-border reachability: top level with sequencer and memories
//
// Input channel (in_valid, in_stall, height): one cell height per transaction,
// row-major, row_count x col_count cells per grid. Cells load one per cycle.
// After the last cell in_stall rises and the block runs by itself:
//   clear of both reach maps, one entry at a time over the whole reach memory
//   seeding: rows + cols seeds per fill, each through both candidate states
//   walk: pop states per popped cell, then a candidate check per neighbor, two states if it exists
//   result: read, mask and emit states per row mask, the emit state held while out_stall holds
// All of this runs on one height read port, one reach map read port and one stack.
// Output channel (out_valid, out_stall, row_index, both_mask, last_row): one
// transaction per row, last_row on the final one. A stalled result holds.
// After the final row the block takes cells of the next grid.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): always ready;
// index 0 row_count, 1 col_count; a write to index 0 or 1 restarts cell loading.
// Reset: sizes go to 1, loading restarts, no result pending.
`include "grid_two_border_reachability_defines.svh"
module grid_two_border_reachability #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLS    = 32,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [HEIGHT_BITS-1:0]       height,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [4:0]                   row_index,
  output logic [31:0]                  both_mask,
  output logic                         last_row,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gtbr_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [gtbr_pkg::CfgDataBits-1:0] cfg_data
);
  import gtbr_pkg::*;

  localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int KW    = $clog2(MAX_ROWS + MAX_COLS);
  localparam int AB    = RB + CB;
  localparam int CELLS = 1 << AB;
  localparam int RROWS = 1 << (RB + 1);
  localparam int SW    = AB + HEIGHT_BITS;

  // configuration
  logic [SizeBits-1:0] row_count;
  logic [SizeBits-1:0] col_count;
  logic [RB-1:0]       rows_m1;
  logic [CB-1:0]       cols_m1;
  logic                cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == CFG_ROW_COUNT || cfg_index == CFG_COL_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= SizeBits'(1);
      col_count <= SizeBits'(1);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROW_COUNT) row_count <= cfg_data[SizeBits-1:0];
      if (cfg_index == CFG_COL_COUNT) col_count <= cfg_data[SizeBits-1:0];
    end
  end

  // clamp sizes to 1..max
  always_comb begin
    if (row_count == '0)
      rows_m1 = '0;
    else if (7'(row_count) > 7'(MAX_ROWS))
      rows_m1 = RB'(MAX_ROWS - 1);
    else
      rows_m1 = RB'(row_count - SizeBits'(1));
    if (col_count == '0)
      cols_m1 = '0;
    else if (7'(col_count) > 7'(MAX_COLS))
      cols_m1 = CB'(MAX_COLS - 1);
    else
      cols_m1 = CB'(col_count - SizeBits'(1));
  end

  // sequencer registers
  state_t           state;
  logic [RB-1:0]    lr;
  logic [CB-1:0]    lc;
  logic [RB:0]      clr;
  logic             fill;
  logic             seeding;
  logic [KW-1:0]    k;
  logic [1:0]       nb;
  logic [RB-1:0]    cur_r;
  logic [CB-1:0]    cur_c;
  logic [HEIGHT_BITS-1:0] cur_h;
  logic [AB:0]      sp;
  logic [RB-1:0]    er;
  logic [MAX_COLS-1:0] m0;

  // memories
  logic [HEIGHT_BITS-1:0] hmem [CELLS];
  logic [HEIGHT_BITS-1:0] hrd;
  logic [MAX_COLS-1:0]    rmem [RROWS];
  logic [MAX_COLS-1:0]    rrd;
  logic [SW-1:0]          smem [CELLS];
  logic [SW-1:0]          srd;

  // candidate cell
  logic          c_ok;
  logic          c_last;
  logic [RB-1:0] c_r;
  logic [CB-1:0] c_c;

  gtbr_cand #(.RB(RB), .CB(CB), .KW(KW)) u_cand (
    .seeding (seeding),
    .fill    (fill),
    .k       (k),
    .nb      (nb),
    .cur_r   (cur_r),
    .cur_c   (cur_c),
    .rows_m1 (rows_m1),
    .cols_m1 (cols_m1),
    .ok      (c_ok),
    .last    (c_last),
    .r       (c_r),
    .c       (c_c)
  );

  logic          in_acc;
  logic          hit;
  logic          out_load;
  logic [RB:0]   r_raddr;
  logic [AB-1:0] sp_m1;

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign hit      = !rrd[c_c] && (seeding || (hrd >= cur_h));
  assign out_load = (state == S_EMIT3) && (!out_valid || !out_stall);
  assign sp_m1    = AB'(sp - (AB+1)'(1));

  // reach map read address
  always_comb begin
    unique case (state)
      S_EMIT1:          r_raddr = {1'b0, er};
      S_EMIT2, S_EMIT3: r_raddr = {1'b1, er};
      default:          r_raddr = {fill, c_r};
    endcase
  end

  // height store
  always_ff @(posedge clk) begin
    if (in_acc) hmem[{lr, lc}] <= height;
    hrd <= hmem[{c_r, c_c}];
  end

  // reach maps, one row word per entry, both fills in one memory
  always_ff @(posedge clk) begin
    if (state == S_CLR)
      rmem[clr] <= '0;
    else if (state == S_CAND_B && c_ok && hit)
      rmem[{fill, c_r}] <= rrd | (MAX_COLS'(1) << c_c);
    rrd <= rmem[r_raddr];
  end

  // walk stack
  always_ff @(posedge clk) begin
    if (state == S_CAND_B && c_ok && hit) smem[sp[AB-1:0]] <= {c_r, c_c, hrd};
    if (state == S_POP1) srd <= smem[sp_m1];
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      lr      <= '0;
      lc      <= '0;
      sp      <= '0;
      seeding <= 1'b0;
      fill    <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (cfg_hit) begin
            lr <= '0;
            lc <= '0;
          end else if (in_acc) begin
            if (lc == cols_m1) begin
              lc <= '0;
              if (lr == rows_m1) begin
                lr    <= '0;
                clr   <= '0;
                state <= S_CLR;
              end else begin
                lr <= lr + RB'(1);
              end
            end else begin
              lc <= lc + CB'(1);
            end
          end
        end
        S_CLR: begin
          clr <= clr + (RB+1)'(1);
          if (clr == (RB+1)'(RROWS - 1)) begin
            fill    <= 1'b0;
            seeding <= 1'b1;
            k       <= '0;
            sp      <= '0;
            state   <= S_CAND_A;
          end
        end
        S_CAND_A, S_CAND_B: begin
          if (state == S_CAND_A && c_ok) begin
            state <= S_CAND_B;
          end else begin
            if (state == S_CAND_B && hit) sp <= sp + (AB+1)'(1);
            if (c_last) begin
              seeding <= 1'b0;
              state   <= S_POP1;
            end else begin
              if (seeding) k <= k + KW'(1);
              else nb <= nb + 2'd1;
              state <= S_CAND_A;
            end
          end
        end
        S_POP1: begin
          if (sp != '0) begin
            sp    <= sp - (AB+1)'(1);
            state <= S_POP2;
          end else if (!fill) begin
            fill    <= 1'b1;
            seeding <= 1'b1;
            k       <= '0;
            state   <= S_CAND_A;
          end else begin
            er    <= '0;
            state <= S_EMIT1;
          end
        end
        S_POP2: begin
          {cur_r, cur_c, cur_h} <= srd;
          nb    <= 2'd0;
          state <= S_CAND_A;
        end
        S_EMIT1: state <= S_EMIT2;
        S_EMIT2: begin
          m0    <= rrd;
          state <= S_EMIT3;
        end
        S_EMIT3: begin
          if (out_load) begin
            if (er == rows_m1) begin
              state <= S_LOAD;
            end else begin
              er    <= er + RB'(1);
              state <= S_EMIT1;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // output register
  logic [RB+4:0]        er_ext;
  logic [MAX_COLS+31:0] mask_ext;

  assign er_ext   = (RB+5)'(er);
  assign mask_ext = (MAX_COLS+32)'(m0 & rrd);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row_index <= er_ext[4:0];
      both_mask <= mask_ext[31:0];
      last_row  <= (er == rows_m1);
    end
  end

  // checks
  `GTBR_ASSERT(a_sp_bound, sp <= (AB+1)'(CELLS), "walk stack overflow")
  `GTBR_ASSERT_NEXT(a_pop_nonempty, state == S_POP1 && sp != '0, state == S_POP2, "pop did not follow")
  `GTBR_ASSERT_NEXT(a_out_from_emit, !out_valid && !(state == S_EMIT3), !out_valid, "result without emit")
  `GTBR_ASSERT(a_stall_busy, (state == S_LOAD) || in_stall, "input taken while busy")

endmodule

/* sim/tb_top.sv */
// testbench for the grid two-border reachability block: predictor, drivers and checks

// one expected row mask transaction
typedef struct packed {
  logic [4:0]  row;
  logic [31:0] mask;
  logic        last;
} row_mask_t;

class reach_scoreboard;
  logic [5:0]  rows_reg;
  logic [5:0]  cols_reg;
  int          loaded;
  logic [15:0] grid_height [1024];
  row_mask_t   pending_rows [$];
  int          mismatches;

  function new();
    rows_reg   = 6'd1;
    cols_reg   = 6'd1;
    loaded     = 0;
    mismatches = 0;
  endfunction

  // zero counts as one, large values saturate at 32
  function int eff_size(logic [5:0] v);
    if (v == 0) return 1;
    if (v > 32) return 32;
    return v;
  endfunction

  // register write: a known index restarts loading
  function void note_config(logic [7:0] idx, logic [7:0] data);
    if (idx == gtbr_pkg::CFG_ROW_COUNT) rows_reg = data[5:0];
    else if (idx == gtbr_pkg::CFG_COL_COUNT) cols_reg = data[5:0];
    else return;
    loaded = 0;
  endfunction

  // fill from a set of seeds, moving uphill or level
  function void fill_reach(int rows, int cols, bit from_low, ref bit reach [1024]);
    int stack [$];
    int idx, r, c, nb, k;
    for (k = 0; k < 1024; k++) reach[k] = 0;
    for (c = 0; c < cols; c++) begin
      idx = from_low ? c : (rows - 1) * cols + c;
      if (!reach[idx]) begin reach[idx] = 1; stack.push_back(idx); end
    end
    for (r = 0; r < rows; r++) begin
      idx = from_low ? r * cols : r * cols + cols - 1;
      if (!reach[idx]) begin reach[idx] = 1; stack.push_back(idx); end
    end
    while (stack.size() > 0) begin
      idx = stack.pop_back();
      r = idx / cols;
      c = idx % cols;
      for (k = 0; k < 4; k++) begin
        nb = -1;
        if (k == 0 && r > 0) nb = idx - cols;
        if (k == 1 && r + 1 < rows) nb = idx + cols;
        if (k == 2 && c > 0) nb = idx - 1;
        if (k == 3 && c + 1 < cols) nb = idx + 1;
        if (nb >= 0 && !reach[nb] && grid_height[nb] >= grid_height[idx]) begin
          reach[nb] = 1;
          stack.push_back(nb);
        end
      end
    end
  endfunction

  // accepted cell: store it, and on the last one predict every row mask
  function void note_cell(logic [15:0] h);
    int rows, cols, r, c;
    bit low_reach [1024];
    bit high_reach [1024];
    row_mask_t e;
    rows = eff_size(rows_reg);
    cols = eff_size(cols_reg);
    if (loaded >= rows * cols) loaded = 0;
    grid_height[loaded] = h;
    loaded++;
    if (loaded < rows * cols) return;
    loaded = 0;
    fill_reach(rows, cols, 1'b1, low_reach);
    fill_reach(rows, cols, 1'b0, high_reach);
    for (r = 0; r < rows; r++) begin
      e.row  = r[4:0];
      e.mask = '0;
      for (c = 0; c < cols; c++)
        if (low_reach[r * cols + c] && high_reach[r * cols + c]) e.mask[c] = 1'b1;
      e.last = (r + 1 == rows);
      pending_rows.push_back(e);
    end
  endfunction

  // compare one output transaction with the oldest prediction
  function void check_row(logic [4:0] row, logic [31:0] mask, logic last);
    row_mask_t e;
    if (pending_rows.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected row mask: row %0d mask %h last %b", row, mask, last);
      return;
    end
    e = pending_rows.pop_front();
    if (row !== e.row || mask !== e.mask || last !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("row mask mismatch: exp row %0d mask %h last %b, got row %0d mask %h last %b",
                 e.row, e.mask, e.last, row, mask, last);
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] height = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  row_index;
  logic [31:0] both_mask;
  logic        last_row;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  reach_scoreboard sb = new();
  int cycles = 0;
  int cells_sent = 0;
  int hold_cycles = 0;

  grid_two_border_reachability DUT (
    .clk, .rst, .in_valid, .in_stall, .height, .out_valid, .out_stall,
    .row_index, .both_mask, .last_row, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // timeout guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stall, with a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (cycles % 2000 < 400) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (pick_gap() > 0);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_row(row_index, both_mask, last_row);
  end

  // one cell transaction; valid stays high when the next one has no gap
  task automatic send_cell(logic [15:0] h);
    int gap;
    gap = (cycles % 3000 < 500) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    height   = h;
    do @(posedge clk); while (in_stall);
    sb.note_cell(h);
    cells_sent++;
    @(negedge clk);
  endtask

  // register write once the block has gone quiet
  task automatic write_reg(logic [7:0] idx, logic [7:0] data);
    in_valid = 1'b0;
    while (sb.pending_rows.size() > 0) @(negedge clk);
    repeat (100) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] rand_height();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return 16'($urandom_range(0, 3));
    if (p < 7) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom());
  endfunction

  task automatic send_grid(int n);
    repeat (n) send_cell(rand_height());
  endtask

  initial begin
    int rows, cols, pass;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: single cell extremes at reset size
    send_cell(16'h0000);
    send_cell(16'hFFFF);
    // size zero reads as one
    write_reg(gtbr_pkg::CFG_ROW_COUNT, 8'd0);
    write_reg(gtbr_pkg::CFG_COL_COUNT, 8'd0);
    send_cell(16'h8000);
    // 2x2 with a pit, a peak and a plateau
    write_reg(gtbr_pkg::CFG_ROW_COUNT, 8'd2);
    write_reg(gtbr_pkg::CFG_COL_COUNT, 8'd2);
    send_cell(16'hFFFF); send_cell(16'h0000); send_cell(16'h0000); send_cell(16'hFFFF);
    send_cell(16'h0005); send_cell(16'h0005); send_cell(16'h0005); send_cell(16'h0005);
    // unknown index is ignored, sizes stay 2x2
    write_reg(8'd2, 8'd7);
    write_reg(8'hFF, 8'd1);
    send_cell(16'h0001); send_cell(16'h0002); send_cell(16'h0003); send_cell(16'h0004);
    // a size write mid-grid drops the loaded cells
    send_cell(16'h0009); send_cell(16'h0001);
    write_reg(gtbr_pkg::CFG_COL_COUNT, 8'd3);
    send_grid(6);

    // random grids
    pass = 0;
    while (cells_sent < 230) begin
      case (pass)
        0: begin rows = 1; cols = 32; end
        1: begin rows = 32; cols = 1; end
        2: begin rows = 63; cols = 2; end
        default: begin
          rows = $urandom_range(1, 6);
          cols = $urandom_range(1, 8);
          if ($urandom_range(0, 9) == 0) rows = 0;
          if ($urandom_range(0, 9) == 0) cols = 0;
        end
      endcase
      // high bits of the data byte are dropped by the register
      write_reg(gtbr_pkg::CFG_ROW_COUNT, {2'($urandom_range(0, 3)), 6'(rows)});
      write_reg(gtbr_pkg::CFG_COL_COUNT, {2'($urandom_range(0, 3)), 6'(cols)});
      if ($urandom_range(0, 9) == 0) write_reg(8'($urandom_range(2, 255)), 8'($urandom()));
      rows = sb.eff_size(sb.rows_reg);
      cols = sb.eff_size(sb.cols_reg);
      // occasional extra grid of random length, abandoned by the next write if cut short
      if ($urandom_range(0, 7) == 0) begin
        send_grid($urandom_range(1, rows * cols));
        write_reg(gtbr_pkg::CFG_ROW_COUNT, 8'(rows));
      end
      if (pass == 1) hold_cycles = 3000;
      send_grid(rows * cols * ((pass < 3) ? 1 : $urandom_range(1, 2)));
      pass++;
    end
    in_valid = 1'b0;

    while (sb.pending_rows.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
